// ===== hdl/mtf_pkg.sv =====
// mtf_pkg: sizes, codes and payload types of the move-to-front lru table
// no dependencies
`timescale 1ns / 1ps

package mtf_pkg;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned HANDLE_BITS = 16;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_e;

  typedef struct packed {
    logic                   action;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } mtf_req_t;

  typedef struct packed {
    logic                   hit;
    logic [HANDLE_BITS-1:0] found_handle;
    logic                   release_valid;
    logic [HANDLE_BITS-1:0] release_handle;
  } mtf_rsp_t;

  // entry contents handed from one cell to the next
  typedef struct packed {
    logic                   valid;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } mtf_entry_t;

  // front-to-back search chain
  typedef struct packed {
    logic                   hit;
    logic [HANDLE_BITS-1:0] found;
  } mtf_chain_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                cmp_en;
    logic [KEY_BITS-1:0] key;
    logic                upd_en;
    logic                any_hit;
    logic                insert;
  } mtf_ctrl_t;

endpackage

// ===== hdl/mtf_if.sv =====
// mtf_req_if and mtf_rsp_if: valid/ready channels of the lru table
// depends on mtf_pkg
`timescale 1ns / 1ps

interface mtf_req_if import mtf_pkg::*;;
  logic     valid;
  logic     ready;
  mtf_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mtf_rsp_if import mtf_pkg::*;;
  logic     valid;
  logic     ready;
  mtf_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/mtf_cell.sv =====
// mtf_cell: one slot of the recency-ordered table
// holds an entry, compares its key and shifts from its front neighbor
// depends on mtf_pkg
`timescale 1ns / 1ps

module mtf_cell import mtf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mtf_ctrl_t  ctrl_i,
  input  mtf_entry_t prev_i,
  output mtf_entry_t entry_o,
  input  mtf_chain_t chain_i,
  output mtf_chain_t chain_o
);

  logic                   valid_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   match_q;
  logic                   first;
  logic                   move;

  assign first = match_q && !chain_i.hit;
  assign move  = ctrl_i.upd_en && (ctrl_i.any_hit ? !chain_i.hit : ctrl_i.insert);

  assign chain_o.hit   = chain_i.hit || match_q;
  assign chain_o.found = chain_i.found | (first ? handle_q : '0);

  assign entry_o.valid  = valid_q;
  assign entry_o.key    = key_q;
  assign entry_o.handle = handle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.cmp_en) begin
        match_q <= valid_q && (key_q == ctrl_i.key);
      end
      if (move) begin
        valid_q <= prev_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      key_q    <= prev_i.key;
      handle_q <= prev_i.handle;
    end
  end

endmodule

// ===== hdl/move_to_front_lru_table.sv =====
// move_to_front_lru_table: top level, controller and row of table cells
// depends on mtf_pkg, mtf_if and mtf_cell
//
// usage:
//   req_i carries one request per transfer: action (lookup or insert), key
//   and handle. rsp_o returns one result per request: hit, found_handle,
//   release_valid and release_handle, in request order.
//   the cycle of a request transfer compares the key against every cell;
//   the update state then takes the front-most match, moves the entries and
//   loads the result register once the output register is free.
//   no new request is taken until the last one has shifted: the compare
//   and the shift of the cell row share the table state, and req_i.ready
//   drops for the shift. a new request is taken while a result still waits
//   in the output register; its shift then waits until that result is
//   transferred. reset empties the table at once by clearing every valid
//   bit; the block takes requests as soon as reset is released.
//   a stalled rsp_o holds its payload.
`timescale 1ns / 1ps

module move_to_front_lru_table import mtf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtf_req_if.sink   req_i,
  mtf_rsp_if.source rsp_o
);

  state_e     state_q, state_d;
  mtf_req_t   req_q;
  mtf_rsp_t   rsp_q, rsp_d;
  logic       rsp_valid_q;
  logic       req_fire;
  mtf_ctrl_t  ctrl;
  mtf_entry_t link [ENTRIES+1];
  mtf_chain_t chain [ENTRIES+1];
  mtf_chain_t chain_end;
  mtf_entry_t tail;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign chain_end = chain[ENTRIES];
  assign tail      = link[ENTRIES];

  assign ctrl.cmp_en  = req_fire;
  assign ctrl.key     = req_i.payload.key;
  assign ctrl.upd_en  = (state_q == ST_UPD) && (!rsp_valid_q || rsp_o.ready);
  assign ctrl.any_hit = chain_end.hit;
  assign ctrl.insert  = (req_q.action == ACT_INSERT);

  // front entry: the hit entry or the new pair
  assign link[0].valid  = 1'b1;
  assign link[0].key    = req_q.key;
  assign link[0].handle = ctrl.insert ? req_q.handle : chain_end.found;

  assign chain[0].hit   = 1'b0;
  assign chain[0].found = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mtf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .prev_i  (link[i]),
      .entry_o (link[i+1]),
      .chain_i (chain[i]),
      .chain_o (chain[i+1])
    );
  end

  always_comb begin
    rsp_d.hit            = chain_end.hit;
    rsp_d.found_handle   = chain_end.found;
    rsp_d.release_valid  = ctrl.insert && (chain_end.hit || tail.valid);
    rsp_d.release_handle = '0;
    if (ctrl.insert) begin
      if (chain_end.hit) begin
        rsp_d.release_handle = chain_end.found;
      end else if (tail.valid) begin
        rsp_d.release_handle = tail.handle;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (ctrl.upd_en) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.upd_en) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i.payload;
    end
    if (ctrl.upd_en) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

// ===== hdl/mtf_checker.sv =====
// mtf_checker: port-level checks of move_to_front_lru_table, and its bind
// depends on mtf_pkg and move_to_front_lru_table
`timescale 1ns / 1ps

module mtf_checker import mtf_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     req_valid_i,
  input logic     req_ready_i,
  input logic     rsp_valid_i,
  input logic     rsp_ready_i,
  input mtf_rsp_t rsp_i
);

  // ready drops after every request transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken in the shift cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_i.hit |-> rsp_i.found_handle == '0)
    else $error("found handle on a miss");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_i.release_valid |-> rsp_i.release_handle == '0)
    else $error("release handle without release");

  // a replacing insert releases the handle it found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.hit && rsp_i.release_valid
      |-> rsp_i.release_handle == rsp_i.found_handle)
    else $error("replaced handle differs from found handle");

endmodule

bind move_to_front_lru_table mtf_checker u_mtf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.payload)
);
